// ===== sv/imabd_pkg.sv =====
// ----------------------------------------------------------------------------
// imabd_pkg
// Shared types, constants and table functions of the IMA ADPCM byte decoder.
// ----------------------------------------------------------------------------
package imabd_pkg;

  localparam int unsigned CodeWidth  = 4;
  localparam int unsigned IndexWidth = 7;
  localparam int unsigned StepWidth  = 15;
  localparam int unsigned PcmWidth   = 16;

  localparam logic [IndexWidth-1:0] MaxIndex = 7'd88;
  localparam logic [StepWidth-1:0]  MaxStep  = 15'h7FFF;

  typedef logic [IndexWidth-1:0]      index_t;
  typedef logic signed [PcmWidth-1:0] pcm_t;

  typedef struct packed {
    logic [7:0]  code_byte;
    logic        frame_start;
    index_t      start_index_left;
    index_t      start_index_right;
    logic        clear_history;
  } in_item_t;

  typedef struct packed {
    pcm_t first_sample;
    pcm_t second_sample;
  } out_item_t;

  localparam logic [StepWidth-1:0] StepTable [0:88] = '{
    15'h0007, 15'h0008, 15'h0009, 15'h000A, 15'h000B, 15'h000C, 15'h000D, 15'h000F,
    15'h0010, 15'h0012, 15'h0013, 15'h0015, 15'h0017, 15'h001A, 15'h001C, 15'h001F,
    15'h0022, 15'h0026, 15'h0029, 15'h002E, 15'h0032, 15'h0037, 15'h003D, 15'h0043,
    15'h004A, 15'h0051, 15'h0059, 15'h0062, 15'h006C, 15'h0076, 15'h0082, 15'h008F,
    15'h009E, 15'h00AD, 15'h00BF, 15'h00D2, 15'h00E7, 15'h00FE, 15'h0117, 15'h0133,
    15'h0152, 15'h0174, 15'h0199, 15'h01C2, 15'h01EF, 15'h0220, 15'h0256, 15'h0292,
    15'h02D4, 15'h031D, 15'h036C, 15'h03C4, 15'h0424, 15'h048E, 15'h0503, 15'h0583,
    15'h0610, 15'h06AC, 15'h0756, 15'h0812, 15'h08E1, 15'h09C4, 15'h0ABE, 15'h0BD1,
    15'h0CFF, 15'h0E4C, 15'h0FBA, 15'h114D, 15'h1308, 15'h14EF, 15'h1707, 15'h1954,
    15'h1BDD, 15'h1EA6, 15'h21B7, 15'h2516, 15'h28CB, 15'h2CDF, 15'h315C, 15'h364C,
    15'h3BBA, 15'h41B2, 15'h4844, 15'h4F7E, 15'h5771, 15'h6030, 15'h69CE, 15'h7463,
    15'h7FFF
  };

  function automatic index_t imabd_sat_index(input index_t idx);
    return (idx > MaxIndex) ? MaxIndex : idx;
  endfunction

  function automatic logic [StepWidth-1:0] imabd_step(input index_t idx);
    return (idx > MaxIndex) ? MaxStep : StepTable[idx];
  endfunction

endpackage

// ===== sv/imabd_nibble_dec.sv =====
// ----------------------------------------------------------------------------
// imabd_nibble_dec
// Decodes one 4-bit code against a predictor and step index.
// ----------------------------------------------------------------------------
module imabd_nibble_dec
  import imabd_pkg::*;
(
  input  logic [CodeWidth-1:0] code,
  input  pcm_t                 pred_i,
  input  index_t               idx_i,
  output pcm_t                 pred_o,
  output index_t               idx_o
);

  logic [StepWidth-1:0]   step;
  logic [StepWidth+3:0]   prod;
  logic [PcmWidth-1:0]    diff;
  logic signed [17:0]     pred_ext;
  logic signed [17:0]     diff_ext;
  logic signed [17:0]     sum;
  logic [3:0]             adj;
  logic [7:0]             idx_sum;

  assign step     = imabd_step(idx_i);
  assign prod     = (StepWidth+4)'(step) * (StepWidth+4)'({code[2:0], 1'b1});
  assign diff     = prod[StepWidth+3:3];
  assign pred_ext = 18'(pred_i);
  assign diff_ext = $signed({2'b00, diff});
  assign sum      = code[3] ? (pred_ext - diff_ext) : (pred_ext + diff_ext);

  always_comb begin
    if (sum > 18'sd32767) begin
      pred_o = 16'sh7FFF;
    end else if (sum < -18'sd32768) begin
      pred_o = 16'sh8000;
    end else begin
      pred_o = sum[15:0];
    end
  end

  // Small codes step the index down by one; large ones up by 2, 4, 6 or 8.
  assign adj     = {1'b0, code[1:0], 1'b0} + 4'd2;
  assign idx_sum = {1'b0, idx_i} + {4'b0000, adj};

  always_comb begin
    if (!code[2]) begin
      idx_o = (idx_i == '0) ? '0 : idx_i - 7'd1;
    end else begin
      idx_o = (idx_sum > {1'b0, MaxIndex}) ? MaxIndex : idx_sum[6:0];
    end
  end

endmodule

// ===== sv/ima_adpcm_byte_decoder_core.sv =====
// ----------------------------------------------------------------------------
// ima_adpcm_byte_decoder_core
// IMA ADPCM decoder taking one byte of two codes and giving two PCM samples.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while the output is not stalled
// and passes it through the input register and then the result register.
// The channel predictors and step indices are updated as an item moves from
// the input register into the result register, so the loop through up to
// two nibble decoders in series (mono) sets the clock period. cfg_wr_en
// writes stereo_mode (reset 1).
module ima_adpcm_byte_decoder_core
  import imabd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic      stereo_r;
  logic      s1_valid_r;
  in_item_t  s1_data_r;
  logic      out_valid_r;
  out_item_t out_data_r;
  pcm_t      pred0_r, pred1_r;
  index_t    idx0_r, idx1_r;

  logic      advance;
  pcm_t      pred0_in, pred1_in;
  index_t    idx0_in, idx1_in;
  pcm_t      pred_a, pred_b, pred_b_in;
  index_t    idx_a, idx_b, idx_b_in;
  pcm_t      pred0_nxt, pred1_nxt;
  index_t    idx0_nxt, idx1_nxt;

  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Header fields take effect before the byte is decoded.
  assign idx0_in  = s1_data_r.frame_start ? imabd_sat_index(s1_data_r.start_index_left)
                                          : idx0_r;
  assign idx1_in  = s1_data_r.frame_start ? imabd_sat_index(s1_data_r.start_index_right)
                                          : idx1_r;
  assign pred0_in = s1_data_r.clear_history ? '0 : pred0_r;
  assign pred1_in = s1_data_r.clear_history ? '0 : pred1_r;

  imabd_nibble_dec u_dec_hi (
    .code   (s1_data_r.code_byte[7:4]),
    .pred_i (pred0_in),
    .idx_i  (idx0_in),
    .pred_o (pred_a),
    .idx_o  (idx_a)
  );

  // In mono the low nibble continues from the high nibble on the left channel.
  assign pred_b_in = stereo_r ? pred1_in : pred_a;
  assign idx_b_in  = stereo_r ? idx1_in  : idx_a;

  imabd_nibble_dec u_dec_lo (
    .code   (s1_data_r.code_byte[3:0]),
    .pred_i (pred_b_in),
    .idx_i  (idx_b_in),
    .pred_o (pred_b),
    .idx_o  (idx_b)
  );

  assign pred0_nxt = stereo_r ? pred_a   : pred_b;
  assign idx0_nxt  = stereo_r ? idx_a    : idx_b;
  assign pred1_nxt = stereo_r ? pred_b   : pred1_in;
  assign idx1_nxt  = stereo_r ? idx_b    : idx1_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stereo_r    <= 1'b1;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pred0_r     <= '0;
      pred1_r     <= '0;
      idx0_r      <= '0;
      idx1_r      <= '0;
    end else begin
      if (cfg_wr_en) begin
        stereo_r <= cfg_wr_data;
      end
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        pred0_r     <= pred0_nxt;
        pred1_r     <= pred1_nxt;
        idx0_r      <= idx0_nxt;
        idx1_r      <= idx1_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_data_r.first_sample  <= pred_a;
      out_data_r.second_sample <= pred_b;
    end
  end

endmodule

// ===== sv/imabd_checker.sv =====
// ----------------------------------------------------------------------------
// imabd_checker
// Port-level checks of the IMA ADPCM byte decoder, bound to the top level.
// ----------------------------------------------------------------------------
module imabd_checker
  import imabd_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A stalled result item stays offered.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  // A stalled result item keeps its samples.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result item changed while stalled");

  // Nothing comes out in the cycle after reset.
  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item offered right after reset");

  // Input back-pressure only arises from a full pipe behind a stalled output.
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without an output stall");

  // An item accepted into an empty pipe goes on to reach the output.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid && $past(in_ready) && !$past(in_valid)
      |=> ##1 out_valid)
    else $error("accepted item did not reach the output");

endmodule

bind ima_adpcm_byte_decoder_core imabd_checker u_imabd_checker (.*);

// ===== tb/ima_adpcm_byte_decoder_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ima_adpcm_byte_decoder_core_tb
// Self-checking testbench for the IMA ADPCM byte decoder core. A queue-fed
// driver offers code bytes, a clocked monitor checks each pair of samples
// against a behavioral decoder, and phases vary the channel mode and the
// idle and stall rates on both sides.
// ----------------------------------------------------------------------------
module ima_adpcm_byte_decoder_core_tb;
  import imabd_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int TOP_STEP_IDX  = 88;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 160;

  localparam int STEP_SIZE [0:88] = '{
    'h0007, 'h0008, 'h0009, 'h000A, 'h000B, 'h000C, 'h000D, 'h000F,
    'h0010, 'h0012, 'h0013, 'h0015, 'h0017, 'h001A, 'h001C, 'h001F,
    'h0022, 'h0026, 'h0029, 'h002E, 'h0032, 'h0037, 'h003D, 'h0043,
    'h004A, 'h0051, 'h0059, 'h0062, 'h006C, 'h0076, 'h0082, 'h008F,
    'h009E, 'h00AD, 'h00BF, 'h00D2, 'h00E7, 'h00FE, 'h0117, 'h0133,
    'h0152, 'h0174, 'h0199, 'h01C2, 'h01EF, 'h0220, 'h0256, 'h0292,
    'h02D4, 'h031D, 'h036C, 'h03C4, 'h0424, 'h048E, 'h0503, 'h0583,
    'h0610, 'h06AC, 'h0756, 'h0812, 'h08E1, 'h09C4, 'h0ABE, 'h0BD1,
    'h0CFF, 'h0E4C, 'h0FBA, 'h114D, 'h1308, 'h14EF, 'h1707, 'h1954,
    'h1BDD, 'h1EA6, 'h21B7, 'h2516, 'h28CB, 'h2CDF, 'h315C, 'h364C,
    'h3BBA, 'h41B2, 'h4844, 'h4F7E, 'h5771, 'h6030, 'h69CE, 'h7463,
    'h7FFF
  };
  localparam int IDX_ADJUST [0:7] = '{-1, -1, -1, -1, 2, 4, 6, 8};

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      cfg_wr_en = 1'b0;
  logic      cfg_wr_data = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // Decoder state as the testbench tracks it.
  logic   stereo_cfg = 1'b1;
  pcm_t   chan_pcm [2] = '{16'sd0, 16'sd0};
  index_t chan_step_idx [2] = '{7'd0, 7'd0};

  in_item_t  pending_bytes [$];
  out_item_t expected_samples [$];

  int  src_idle_pct = 0;
  int  sink_stall_pct = 0;
  logic sink_hold = 1'b0;
  int  n_errors = 0;
  int  cycle_count = 0;

  ima_adpcm_byte_decoder_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic index_t clamp_start_idx(input index_t v);
    return (v > TOP_STEP_IDX) ? index_t'(TOP_STEP_IDX) : v;
  endfunction

  // Applies one code to a channel and returns the new sample.
  function automatic pcm_t decode_code_nibble(input logic ch, input logic [3:0] code);
    int idx;
    int delta;
    int acc;
    int nxt;
    idx = int'(chan_step_idx[ch]);
    delta = ((2 * int'(code[2:0]) + 1) * STEP_SIZE[idx]) >>> 3;
    acc = int'(chan_pcm[ch]);
    if (code[3]) begin
      acc = acc - delta;
    end else begin
      acc = acc + delta;
    end
    if (acc < -32768) begin
      acc = -32768;
    end else if (acc > 32767) begin
      acc = 32767;
    end
    chan_pcm[ch] = pcm_t'(acc);
    nxt = idx + IDX_ADJUST[code[2:0]];
    if (nxt < 0) begin
      nxt = 0;
    end else if (nxt > TOP_STEP_IDX) begin
      nxt = TOP_STEP_IDX;
    end
    chan_step_idx[ch] = index_t'(nxt);
    return chan_pcm[ch];
  endfunction

  function automatic void predict_byte_samples(input in_item_t it);
    out_item_t r;
    if (it.frame_start) begin
      chan_step_idx[0] = clamp_start_idx(it.start_index_left);
      chan_step_idx[1] = clamp_start_idx(it.start_index_right);
    end
    if (it.clear_history) begin
      chan_pcm[0] = '0;
      chan_pcm[1] = '0;
    end
    r.first_sample  = decode_code_nibble(1'b0, it.code_byte[7:4]);
    r.second_sample = decode_code_nibble(stereo_cfg, it.code_byte[3:0]);
    expected_samples.push_back(r);
  endfunction

  function automatic in_item_t mk_item(input logic [7:0] code, input logic fs,
                                       input index_t left, input index_t right,
                                       input logic clr);
    in_item_t it;
    it.code_byte         = code;
    it.frame_start       = fs;
    it.start_index_left  = left;
    it.start_index_right = right;
    it.clear_history     = clr;
    return it;
  endfunction

  function automatic index_t rand_start_idx();
    if ($urandom_range(99) < 12) begin
      return index_t'($urandom_range(127, TOP_STEP_IDX + 1));
    end
    return index_t'($urandom_range(TOP_STEP_IDX));
  endfunction

  // Mostly plain frames of random codes, with occasional one-signed bursts that
  // drive the predictor into saturation.
  task automatic queue_random_bytes(input int n);
    int burst_left;
    logic burst_neg;
    logic [7:0] code;
    burst_left = 0;
    burst_neg = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (burst_left == 0 && $urandom_range(99) < 5) begin
        burst_left = $urandom_range(24, 8);
        burst_neg = 1'($urandom_range(1));
      end
      code = 8'($urandom_range(255));
      if (burst_left > 0) begin
        code[7] = burst_neg;
        code[3] = burst_neg;
        burst_left--;
      end
      pending_bytes.push_back(mk_item(code, $urandom_range(99) < 6, rand_start_idx(),
                                      rand_start_idx(), $urandom_range(99) < 4));
    end
  endtask

  task automatic write_stereo_mode(input logic v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    stereo_cfg = v;
    @(negedge clk);
  endtask

  task automatic wait_until_drained();
    do begin
      @(negedge clk);
    end while (pending_bytes.size() != 0 || in_valid || expected_samples.size() != 0);
  endtask

  // Driver: an offered item is held until accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_byte_samples(in_data);
      end
      if (!in_valid || in_ready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          in_data  <= pending_bytes.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest prediction.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          $error("unexpected result item: first_sample %0d, second_sample %0d",
                 out_data.first_sample, out_data.second_sample);
          n_errors++;
        end else begin
          want = expected_samples.pop_front();
          if (out_data.first_sample !== want.first_sample) begin
            $error("first_sample mismatch: expected %0d, actual %0d",
                   want.first_sample, out_data.first_sample);
            n_errors++;
          end
          if (out_data.second_sample !== want.second_sample) begin
            $error("second_sample mismatch: expected %0d, actual %0d",
                   want.second_sample, out_data.second_sample);
            n_errors++;
          end
        end
      end
      out_ready <= !sink_hold && ($urandom_range(99) >= sink_stall_pct);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed stereo items: idle decode, index clamping at both ends,
    // saturation both ways, start indices above the table, and both flags.
    write_stereo_mode(1'b1);
    pending_bytes.push_back(mk_item(8'h00, 1'b0, 7'd0, 7'd0, 1'b0));
    pending_bytes.push_back(mk_item(8'hFF, 1'b0, 7'd0, 7'd0, 1'b0));
    pending_bytes.push_back(mk_item(8'h77, 1'b1, 7'd88, 7'd88, 1'b0));
    pending_bytes.push_back(mk_item(8'h77, 1'b0, 7'd0, 7'd0, 1'b0));
    pending_bytes.push_back(mk_item(8'h88, 1'b0, 7'd127, 7'd127, 1'b0));
    pending_bytes.push_back(mk_item(8'hFF, 1'b1, 7'd127, 7'd89, 1'b0));
    pending_bytes.push_back(mk_item(8'hFF, 1'b0, 7'd0, 7'd0, 1'b0));
    pending_bytes.push_back(mk_item(8'hF0, 1'b0, 7'd0, 7'd0, 1'b0));
    pending_bytes.push_back(mk_item(8'h80, 1'b1, 7'd0, 7'd0, 1'b1));
    pending_bytes.push_back(mk_item(8'h08, 1'b0, 7'd85, 7'd42, 1'b1));
    pending_bytes.push_back(mk_item(8'h00, 1'b1, 7'd0, 7'd0, 1'b0));
    pending_bytes.push_back(mk_item(8'h3B, 1'b0, 7'd0, 7'd0, 1'b0));
    pending_bytes.push_back(mk_item(8'h5C, 1'b1, 7'd64, 7'd21, 1'b0));
    pending_bytes.push_back(mk_item(8'hA6, 1'b0, 7'd0, 7'd0, 1'b1));
    wait_until_drained();

    // Mono: a frame start loads both indices but only the left one is used.
    write_stereo_mode(1'b0);
    pending_bytes.push_back(mk_item(8'h7F, 1'b1, 7'd10, 7'd50, 1'b0));
    pending_bytes.push_back(mk_item(8'h00, 1'b0, 7'd0, 7'd0, 1'b0));
    pending_bytes.push_back(mk_item(8'h77, 1'b1, 7'd88, 7'd0, 1'b0));
    pending_bytes.push_back(mk_item(8'h77, 1'b0, 7'd0, 7'd0, 1'b0));
    pending_bytes.push_back(mk_item(8'hFF, 1'b0, 7'd0, 7'd0, 1'b0));
    pending_bytes.push_back(mk_item(8'hF9, 1'b0, 7'd0, 7'd0, 1'b1));
    wait_until_drained();
    write_stereo_mode(1'b1);
    pending_bytes.push_back(mk_item(8'h12, 1'b0, 7'd0, 7'd0, 1'b0));
    wait_until_drained();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_stereo_mode(p[0]);
      case (p / 2)
        0: begin
          src_idle_pct = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct = 63;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct = 0;
          sink_stall_pct = 63;
        end
        default: begin
          src_idle_pct = 13;
          sink_stall_pct = 13;
        end
      endcase
      queue_random_bytes(PHASE_ITEMS);
      wait_until_drained();
    end

    // Hold the receiver off while the sender keeps offering, so the core
    // fills and pushes back on its input.
    src_idle_pct = 0;
    sink_stall_pct = 0;
    queue_random_bytes(40);
    @(posedge clk);
    sink_hold <= 1'b1;
    repeat (150) @(posedge clk);
    sink_hold <= 1'b0;
    wait_until_drained();

    repeat (10) @(posedge clk);
    if (n_errors == 0 && expected_samples.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/imabd_pkg.sv
sv/imabd_nibble_dec.sv
sv/ima_adpcm_byte_decoder_core.sv
sv/imabd_checker.sv
tb/ima_adpcm_byte_decoder_core_tb.sv
